/* rtl/brq_pkg.sv */
// Package for the batching retry queue: payload structs, operation and
// status codes, and the reset values of the configuration registers.
// Used by batching_retry_queue_top; depends on nothing.
package brq_pkg;

    localparam int unsigned DEF_QUEUE_DEPTH = 256;
    localparam int unsigned DEF_MAX_BATCH   = 32;

    localparam int unsigned POS_W    = 64;
    localparam int unsigned SIZE_W   = 24;
    localparam int unsigned TYPE_W   = 2;
    localparam int unsigned ORIGIN_W = 10;
    localparam int unsigned META_W   = SIZE_W + TYPE_W + ORIGIN_W;
    localparam int unsigned CFG_W    = 32;
    localparam int unsigned CIDX_W   = 3;
    localparam int unsigned QCNT_W   = 9;
    // A batch holds at most DEF_MAX_BATCH (32) records of under 2^24 bytes, so its sum fits 32 bits.
    localparam int unsigned SUM_W    = 32;

    localparam logic [2:0] FN_PUSH     = 3'd0;
    localparam logic [2:0] FN_FETCH    = 3'd1;
    localparam logic [2:0] FN_ACK_OK   = 3'd2;
    localparam logic [2:0] FN_ACK_FAIL = 3'd3;
    localparam logic [2:0] FN_TICK     = 3'd4;

    localparam logic [1:0] ST_OK      = 2'd0;
    localparam logic [1:0] ST_EMPTY   = 2'd1;
    localparam logic [1:0] ST_FULL    = 2'd2;
    localparam logic [1:0] ST_NOBATCH = 2'd3;

    localparam logic [CIDX_W-1:0] CFG_COUNT_LIMIT = 3'd0;
    localparam logic [CIDX_W-1:0] CFG_SIZE_LIMIT  = 3'd1;
    localparam logic [CIDX_W-1:0] CFG_RETRY_WAIT  = 3'd2;
    localparam logic [CIDX_W-1:0] CFG_CAPACITY    = 3'd3;
    localparam logic [CIDX_W-1:0] CFG_BUCKET      = 3'd4;

    localparam logic [5:0]  RST_COUNT_LIMIT = 6'd10;
    localparam logic [31:0] RST_SIZE_LIMIT  = 32'd1073741824;
    localparam logic [7:0]  RST_RETRY_WAIT  = 8'd2;
    localparam logic [8:0]  RST_CAPACITY    = 9'd256;

    typedef struct packed {
        logic [2:0]          func;
        logic [POS_W-1:0]    rec_position;
        logic [SIZE_W-1:0]   rec_size;
        logic [TYPE_W-1:0]   rec_type;
        logic [ORIGIN_W-1:0] rec_origin_bucket;
    } t_brq_in;

    typedef struct packed {
        logic [1:0]          status;
        logic [POS_W-1:0]    item_position;
        logic [SIZE_W-1:0]   item_size;
        logic [TYPE_W-1:0]   item_type;
        logic [ORIGIN_W-1:0] batch_origin;
        logic                last;
        logic [QCNT_W-1:0]   queue_count;
        logic                is_empty;
        logic                is_full;
        logic                retry_ready;
        logic [POS_W-1:0]    head_position;
    } t_brq_out;

endpackage

/* rtl/batching_retry_queue_top.sv */
// Batching retry queue: ring of record descriptors in two synchronous memories,
// a small sequencer that builds, replays and retires batches, and an output register.
// Depends on brq_pkg.
//
//  Channel   Direction  Signals                              Transfer when
//  input     in         i_valid, o_stall, i_in_data          i_valid && !o_stall
//  result    out        o_valid, i_stall, o_out_data         o_valid && !i_stall
//  config    in         i_cfg_we, i_cfg_index, i_cfg_wdata   i_cfg_we
//
// Push, tick, ack fail and an ack ok that empties the queue are answered from the idle state.
// An ack ok with records behind the batch passes through the ack state, for the read of the new head.
// A fetch that forms a batch first reads the metadata memory once per record to find the
// batch end, then reads each record again and emits one record per read.
// A fetch of a held batch does only the second pass. Both passes share the single read port.
// Reset is synchronous; the memories are not cleared. A stalled result holds the
// sequencer in place, and o_stall stays high while an item is in progress.
module batching_retry_queue_top #(
    parameter int unsigned QUEUE_DEPTH = brq_pkg::DEF_QUEUE_DEPTH,
    parameter int unsigned MAX_BATCH   = brq_pkg::DEF_MAX_BATCH
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_valid,
    output logic                       o_stall,
    input  brq_pkg::t_brq_in           i_in_data,
    output logic                       o_valid,
    input  logic                       i_stall,
    output brq_pkg::t_brq_out          o_out_data,
    input  logic                       i_cfg_we,
    input  logic [brq_pkg::CIDX_W-1:0] i_cfg_index,
    input  logic [brq_pkg::CFG_W-1:0]  i_cfg_wdata
);
    import brq_pkg::*;

    localparam int unsigned PTR_W = $clog2(QUEUE_DEPTH);
    localparam int unsigned CNT_W = $clog2(QUEUE_DEPTH + 1);
    localparam int unsigned BL_W  = $clog2(MAX_BATCH + 1);
    localparam int unsigned LW    = (BL_W > 6) ? BL_W : 6;
    localparam int unsigned CAP_W = (CNT_W > 9) ? CNT_W : 9;
    localparam int unsigned AW    = PTR_W + 1;

    localparam logic [1:0] S_IDLE  = 2'd0;
    localparam logic [1:0] S_BUILD = 2'd1;
    localparam logic [1:0] S_EMIT  = 2'd2;
    localparam logic [1:0] S_ACK   = 2'd3;

    logic [POS_W-1:0]  pos_mem  [QUEUE_DEPTH];
    logic [META_W-1:0] meta_mem [QUEUE_DEPTH];
    logic [POS_W-1:0]  r_pos_rd;
    logic [META_W-1:0] r_meta_rd;

    logic [5:0]          r_cfg_count;
    logic [31:0]         r_cfg_size;
    logic [7:0]          r_cfg_wait;
    logic [8:0]          r_cfg_cap;

    logic [1:0]          r_state, n_state;
    logic [PTR_W-1:0]    r_head, n_head;
    logic [PTR_W-1:0]    r_tail, n_tail;
    logic [PTR_W-1:0]    r_rd_ptr, n_rd_ptr;
    logic [CNT_W-1:0]    r_queued, n_queued;
    logic [BL_W-1:0]     r_blen, n_blen;
    logic [BL_W-1:0]     r_eidx, n_eidx;
    logic                r_held, n_held;
    logic [ORIGIN_W-1:0] r_origin, n_origin;
    logic [7:0]          r_wait, n_wait;
    logic [POS_W-1:0]    r_oldest, n_oldest;
    logic [SUM_W-1:0]    r_sum, n_sum;
    logic                r_out_valid;
    t_brq_out            r_out, n_out;

    logic                out_free;
    logic                in_take;
    logic                out_load;
    logic                wr_en;
    logic                rd_en;
    logic [PTR_W-1:0]    rd_addr;
    logic [1:0]          res_status;
    logic                res_item;
    logic                res_last;
    logic [BL_W-1:0]     lim;
    logic [LW-1:0]       lim_ext;
    logic [CAP_W-1:0]    cap_ext;
    logic [CAP_W-1:0]    eff_cap;
    logic [CNT_W-1:0]    cur_total;
    logic [CNT_W-1:0]    nxt_total;
    logic                cur_full;
    logic                nxt_pending;
    logic [AW-1:0]       head_sum;
    logic [PTR_W-1:0]    head_after;
    logic [BL_W-1:0]     nb;
    logic [SUM_W-1:0]    nsum;
    logic                stop;

    function automatic logic [PTR_W-1:0] ptr_inc(input logic [PTR_W-1:0] p);
        logic [PTR_W-1:0] r;
        r = (p == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : p + 1'b1;
        return r;
    endfunction

    assign out_free = !r_out_valid || !i_stall;
    assign o_stall  = !((r_state == S_IDLE) && out_free);
    assign in_take  = i_valid && !o_stall;
    assign o_valid  = r_out_valid;
    assign o_out_data = r_out;

    always_comb begin
        lim_ext = LW'(r_cfg_count);
        if (r_cfg_count == '0) begin
            lim = BL_W'(1);
        end else if (lim_ext > LW'(MAX_BATCH)) begin
            lim = BL_W'(MAX_BATCH);
        end else begin
            lim = BL_W'(lim_ext);
        end
        cap_ext = CAP_W'(r_cfg_cap);
        eff_cap = (cap_ext > CAP_W'(QUEUE_DEPTH)) ? CAP_W'(QUEUE_DEPTH) : cap_ext;
        cur_total = r_queued + CNT_W'(r_blen);
        cur_full  = CAP_W'(cur_total) >= eff_cap;
        head_sum  = AW'(r_head) + AW'(r_blen);
        head_after = (head_sum >= AW'(QUEUE_DEPTH)) ?
                     PTR_W'(head_sum - AW'(QUEUE_DEPTH)) : PTR_W'(head_sum);
        nb   = r_blen + 1'b1;
        nsum = r_sum + SUM_W'(r_meta_rd[SIZE_W-1:0]);
        stop = (nsum > r_cfg_size) || (nb == lim) || (r_queued == CNT_W'(1));
    end

    always_comb begin
        n_state  = r_state;
        n_head   = r_head;
        n_tail   = r_tail;
        n_rd_ptr = r_rd_ptr;
        n_queued = r_queued;
        n_blen   = r_blen;
        n_eidx   = r_eidx;
        n_held   = r_held;
        n_origin = r_origin;
        n_wait   = r_wait;
        n_oldest = r_oldest;
        n_sum    = r_sum;
        out_load   = 1'b0;
        wr_en      = 1'b0;
        rd_en      = 1'b0;
        rd_addr    = r_head;
        res_status = ST_OK;
        res_item   = 1'b0;
        res_last   = 1'b1;

        unique case (r_state)
            S_IDLE: begin
                if (in_take) begin
                    unique case (i_in_data.func)
                        FN_PUSH: begin
                            out_load = 1'b1;
                            if (cur_full) begin
                                res_status = ST_FULL;
                            end else begin
                                wr_en = 1'b1;
                                if (!r_held && r_queued == '0) begin
                                    n_oldest = i_in_data.rec_position;
                                end
                                n_tail   = ptr_inc(r_tail);
                                n_queued = r_queued + 1'b1;
                            end
                        end
                        FN_FETCH: begin
                            if (r_held) begin
                                rd_en    = 1'b1;
                                n_rd_ptr = ptr_inc(r_head);
                                n_eidx   = '0;
                                n_state  = S_EMIT;
                            end else if (r_queued == '0) begin
                                out_load   = 1'b1;
                                res_status = ST_EMPTY;
                            end else begin
                                rd_en    = 1'b1;
                                n_rd_ptr = ptr_inc(r_head);
                                n_blen   = '0;
                                n_sum    = '0;
                                n_state  = S_BUILD;
                            end
                        end
                        FN_ACK_OK, FN_ACK_FAIL: begin
                            if (!r_held) begin
                                out_load   = 1'b1;
                                res_status = ST_NOBATCH;
                            end else if (i_in_data.func == FN_ACK_FAIL) begin
                                out_load = 1'b1;
                                n_wait   = r_cfg_wait;
                            end else begin
                                n_wait   = '0;
                                n_head   = head_after;
                                n_blen   = '0;
                                n_held   = 1'b0;
                                n_origin = '0;
                                if (r_queued != '0) begin
                                    rd_en   = 1'b1;
                                    rd_addr = head_after;
                                    n_state = S_ACK;
                                end else begin
                                    out_load = 1'b1;
                                end
                            end
                        end
                        FN_TICK: begin
                            out_load = 1'b1;
                            if (r_wait != '0) begin
                                n_wait = r_wait - 1'b1;
                            end
                        end
                        default: begin
                            out_load = 1'b1;
                        end
                    endcase
                end
            end
            S_BUILD: begin
                n_origin = r_meta_rd[META_W-1:SIZE_W+TYPE_W];
                n_blen   = nb;
                n_queued = r_queued - 1'b1;
                n_sum    = nsum;
                rd_en    = 1'b1;
                if (stop) begin
                    n_held   = 1'b1;
                    rd_addr  = r_head;
                    n_rd_ptr = ptr_inc(r_head);
                    n_eidx   = '0;
                    n_state  = S_EMIT;
                end else begin
                    rd_addr  = r_rd_ptr;
                    n_rd_ptr = ptr_inc(r_rd_ptr);
                end
            end
            S_EMIT: begin
                if (out_free) begin
                    out_load = 1'b1;
                    res_item = 1'b1;
                    res_last = (r_eidx + 1'b1) == r_blen;
                    if (res_last) begin
                        n_state = S_IDLE;
                    end else begin
                        rd_en    = 1'b1;
                        rd_addr  = r_rd_ptr;
                        n_rd_ptr = ptr_inc(r_rd_ptr);
                        n_eidx   = r_eidx + 1'b1;
                    end
                end
            end
            S_ACK: begin
                if (out_free) begin
                    out_load = 1'b1;
                    n_oldest = r_pos_rd;
                    n_state  = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_comb begin
        nxt_total   = n_queued + CNT_W'(n_blen);
        nxt_pending = n_held || (n_queued != '0);
        n_out.status        = res_status;
        n_out.item_position = res_item ? r_pos_rd : '0;
        n_out.item_size     = res_item ? r_meta_rd[SIZE_W-1:0] : '0;
        n_out.item_type     = res_item ? r_meta_rd[SIZE_W+TYPE_W-1:SIZE_W] : '0;
        n_out.batch_origin  = n_held ? n_origin : '0;
        n_out.last          = res_last;
        n_out.queue_count   = QCNT_W'(nxt_total);
        n_out.is_empty      = !nxt_pending;
        n_out.is_full       = CAP_W'(nxt_total) >= eff_cap;
        n_out.retry_ready   = nxt_pending && (n_wait == '0);
        n_out.head_position = n_oldest;
    end

    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            pos_mem[r_tail]  <= i_in_data.rec_position;
            meta_mem[r_tail] <= {i_in_data.rec_origin_bucket, i_in_data.rec_type,
                                 i_in_data.rec_size};
        end
        if (rd_en) begin
            r_pos_rd  <= pos_mem[rd_addr];
            r_meta_rd <= meta_mem[rd_addr];
        end
    end

    // The bucket number register has no effect on results, so its write is dropped.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg_count <= RST_COUNT_LIMIT;
            r_cfg_size  <= RST_SIZE_LIMIT;
            r_cfg_wait  <= RST_RETRY_WAIT;
            r_cfg_cap   <= RST_CAPACITY;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                CFG_COUNT_LIMIT: r_cfg_count <= i_cfg_wdata[5:0];
                CFG_SIZE_LIMIT:  r_cfg_size  <= i_cfg_wdata[31:0];
                CFG_RETRY_WAIT:  r_cfg_wait  <= i_cfg_wdata[7:0];
                CFG_CAPACITY:    r_cfg_cap   <= i_cfg_wdata[8:0];
                CFG_BUCKET:      r_cfg_cap   <= r_cfg_cap;
                default:         r_cfg_cap   <= r_cfg_cap;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_head      <= '0;
            r_tail      <= '0;
            r_rd_ptr    <= '0;
            r_queued    <= '0;
            r_blen      <= '0;
            r_eidx      <= '0;
            r_held      <= 1'b0;
            r_origin    <= '0;
            r_wait      <= '0;
            r_oldest    <= '0;
            r_sum       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_head   <= n_head;
            r_tail   <= n_tail;
            r_rd_ptr <= n_rd_ptr;
            r_queued <= n_queued;
            r_blen   <= n_blen;
            r_eidx   <= n_eidx;
            r_held   <= n_held;
            r_origin <= n_origin;
            r_wait   <= n_wait;
            r_oldest <= n_oldest;
            r_sum    <= n_sum;
            if (out_load) begin
                r_out_valid <= 1'b1;
            end else if (!i_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (out_load) begin
            r_out <= n_out;
        end
    end

endmodule

/* verif/brq_result_checker.sv */
// Result checker for the batching retry queue: tracks the queue state and the five
// configuration registers, predicts every result transfer and compares it field by field.
// Depends on brq_pkg; instantiated beside the block by batching_retry_queue_top_tb.
module brq_result_checker (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_in_valid,
    input  logic                         i_in_stall,
    input  brq_pkg::t_brq_in             i_in_data,
    input  logic                         i_out_valid,
    input  logic                         i_out_stall,
    input  brq_pkg::t_brq_out            i_out_data,
    input  logic                         i_cfg_we,
    input  logic [brq_pkg::CIDX_W-1:0]   i_cfg_index,
    input  logic [brq_pkg::CFG_W-1:0]    i_cfg_wdata,
    output int                           o_fail_count,
    output int                           o_pending,
    output int                           o_checked
);
    import brq_pkg::*;

    localparam int unsigned DEPTH = DEF_QUEUE_DEPTH;
    localparam int unsigned MAXB  = DEF_MAX_BATCH;

    logic [POS_W-1:0]    pos_mem    [DEPTH];
    logic [SIZE_W-1:0]   size_mem   [DEPTH];
    logic [TYPE_W-1:0]   type_mem   [DEPTH];
    logic [ORIGIN_W-1:0] origin_mem [DEPTH];

    int unsigned         head, tail, queued, blen, wait_cnt;
    bit                  held;
    logic [ORIGIN_W-1:0] borigin;
    logic [POS_W-1:0]    oldest;

    logic [5:0]          count_lim;
    logic [31:0]         size_lim;
    logic [7:0]          retry_ticks;
    logic [8:0]          capacity;
    logic [9:0]          bucket;

    t_brq_out            expected_results [$];
    int                  fails, checked;

    function automatic int unsigned usable_capacity();
        return (capacity > DEPTH) ? DEPTH : capacity;
    endfunction

    function automatic void append_result(t_brq_out r);
        expected_results.insert(expected_results.size(), r);
    endfunction

    function automatic t_brq_out queue_status_word(logic [1:0] st, bit has_item,
                                                   int unsigned ix, bit lst);
        t_brq_out    r;
        int unsigned total;
        bit          busy;
        total = queued + blen;
        busy  = held || queued > 0;
        r = '0;
        r.status = st;
        if (has_item) begin
            r.item_position = pos_mem[ix];
            r.item_size     = size_mem[ix];
            r.item_type     = type_mem[ix];
        end
        r.batch_origin  = held ? borigin : '0;
        r.last          = lst;
        r.queue_count   = total[QCNT_W-1:0];
        r.is_empty      = !busy;
        r.is_full       = total >= usable_capacity();
        r.retry_ready   = busy && wait_cnt == 0;
        r.head_position = oldest;
        return r;
    endfunction

    task automatic predict_queue_step(t_brq_in d);
        int unsigned lim, ix;
        logic [63:0] sum;
        bit          stop;
        case (d.func)
            FN_PUSH: begin
                if (queued + blen >= usable_capacity()) begin
                    append_result(queue_status_word(ST_FULL, 0, 0, 1));
                end else begin
                    if (!held && queued == 0) oldest = d.rec_position;
                    pos_mem[tail]    = d.rec_position;
                    size_mem[tail]   = d.rec_size;
                    type_mem[tail]   = d.rec_type;
                    origin_mem[tail] = d.rec_origin_bucket;
                    tail = (tail + 1) % DEPTH;
                    queued++;
                    append_result(queue_status_word(ST_OK, 0, 0, 1));
                end
            end
            FN_FETCH: begin
                if (!held && queued == 0) begin
                    append_result(queue_status_word(ST_EMPTY, 0, 0, 1));
                end else begin
                    if (!held) begin
                        lim = count_lim;
                        if (lim == 0) lim = 1;
                        if (lim > MAXB) lim = MAXB;
                        blen = 0;
                        sum  = '0;
                        stop = 0;
                        while (!stop && blen < lim && queued > 0) begin
                            ix = (head + blen) % DEPTH;
                            borigin = origin_mem[ix];
                            blen++;
                            queued--;
                            sum += size_mem[ix];
                            if (sum > size_lim) stop = 1;
                        end
                        held = 1;
                    end
                    for (int unsigned k = 0; k < blen; k++) begin
                        append_result(
                            queue_status_word(ST_OK, 1, (head + k) % DEPTH, k + 1 == blen));
                    end
                end
            end
            FN_ACK_OK, FN_ACK_FAIL: begin
                if (!held) begin
                    append_result(queue_status_word(ST_NOBATCH, 0, 0, 1));
                end else begin
                    if (d.func == FN_ACK_OK) begin
                        wait_cnt = 0;
                        head     = (head + blen) % DEPTH;
                        blen     = 0;
                        held     = 0;
                        borigin  = '0;
                        if (queued > 0) oldest = pos_mem[head];
                    end else begin
                        wait_cnt = retry_ticks;
                    end
                    append_result(queue_status_word(ST_OK, 0, 0, 1));
                end
            end
            FN_TICK: begin
                if (wait_cnt > 0) wait_cnt--;
                append_result(queue_status_word(ST_OK, 0, 0, 1));
            end
            default: begin
                append_result(queue_status_word(ST_OK, 0, 0, 1));
            end
        endcase
    endtask

    function automatic bit field_ok(string name, logic [63:0] exp_v, logic [63:0] act_v);
        if (exp_v !== act_v) begin
            $display("%0t: %s expected %0h, got %0h", $time, name, exp_v, act_v);
            return 0;
        end
        return 1;
    endfunction

    always @(posedge i_clk) begin
        t_brq_out want;
        bit       ok;
        if (!i_rst_n) begin
            head = 0; tail = 0; queued = 0; blen = 0; wait_cnt = 0;
            held = 0; borigin = '0; oldest = '0;
            count_lim   = RST_COUNT_LIMIT;
            size_lim    = RST_SIZE_LIMIT;
            retry_ticks = RST_RETRY_WAIT;
            capacity    = RST_CAPACITY;
            bucket      = '0;
            expected_results.delete();
            fails   = 0;
            checked = 0;
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_index)
                    CFG_COUNT_LIMIT: count_lim   = i_cfg_wdata[5:0];
                    CFG_SIZE_LIMIT:  size_lim    = i_cfg_wdata[31:0];
                    CFG_RETRY_WAIT:  retry_ticks = i_cfg_wdata[7:0];
                    CFG_CAPACITY:    capacity    = i_cfg_wdata[8:0];
                    CFG_BUCKET:      bucket      = i_cfg_wdata[9:0];
                    default: ;
                endcase
            end
            if (i_out_valid && !i_out_stall) begin
                if (expected_results.size() == 0) begin
                    fails++;
                    $display("%0t: result transfer with nothing expected, got %h",
                             $time, i_out_data);
                end else begin
                    want = expected_results.pop_front();
                    ok = 1;
                    ok = field_ok("status", want.status, i_out_data.status) && ok;
                    ok = field_ok("item_position", want.item_position,
                                  i_out_data.item_position) && ok;
                    ok = field_ok("item_size", want.item_size, i_out_data.item_size) && ok;
                    ok = field_ok("item_type", want.item_type, i_out_data.item_type) && ok;
                    ok = field_ok("batch_origin", want.batch_origin,
                                  i_out_data.batch_origin) && ok;
                    ok = field_ok("last", want.last, i_out_data.last) && ok;
                    ok = field_ok("queue_count", want.queue_count,
                                  i_out_data.queue_count) && ok;
                    ok = field_ok("is_empty", want.is_empty, i_out_data.is_empty) && ok;
                    ok = field_ok("is_full", want.is_full, i_out_data.is_full) && ok;
                    ok = field_ok("retry_ready", want.retry_ready,
                                  i_out_data.retry_ready) && ok;
                    ok = field_ok("head_position", want.head_position,
                                  i_out_data.head_position) && ok;
                    if (!ok) fails++;
                    checked++;
                end
            end
            if (i_in_valid && !i_in_stall) predict_queue_step(i_in_data);
        end
        o_fail_count <= fails;
        o_pending    <= expected_results.size();
        o_checked    <= checked;
    end

endmodule

/* verif/batching_retry_queue_top_tb.sv */
// Testbench top for batching_retry_queue_top: clock, reset, stimulus, random stalls
// and the verdict. Depends on brq_pkg and on brq_result_checker, which does the checking.
module batching_retry_queue_top_tb;
    import brq_pkg::*;

    localparam int CYCLE_LIMIT  = 1_000_000;
    localparam int HOLD_CYCLES  = 300;
    localparam int DRAIN_CYCLES = 80;
    localparam int PHASE_ITEMS  = 27;

    localparam logic [TYPE_W-1:0] REC_PUT    = 2'd0;
    localparam logic [TYPE_W-1:0] REC_DELETE = 2'd1;
    localparam logic [TYPE_W-1:0] REC_OTHER  = 2'd2;

    logic                i_clk;
    logic                i_rst_n;
    logic                i_valid;
    logic                o_stall;
    t_brq_in             i_in_data;
    logic                o_valid;
    logic                i_stall;
    t_brq_out            o_out_data;
    logic                i_cfg_we;
    logic [CIDX_W-1:0]   i_cfg_index;
    logic [CFG_W-1:0]    i_cfg_wdata;

    int fail_count, pending, checked;
    int n_items, n_settings;
    bit tx_burst, rx_burst, hold_req;

    batching_retry_queue_top dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (i_valid),
        .o_stall     (o_stall),
        .i_in_data   (i_in_data),
        .o_valid     (o_valid),
        .i_stall     (i_stall),
        .o_out_data  (o_out_data),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_wdata (i_cfg_wdata)
    );

    brq_result_checker u_results (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (i_valid),
        .i_in_stall   (o_stall),
        .i_in_data    (i_in_data),
        .i_out_valid  (o_valid),
        .i_out_stall  (i_stall),
        .i_out_data   (o_out_data),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_index  (i_cfg_index),
        .i_cfg_wdata  (i_cfg_wdata),
        .o_fail_count (fail_count),
        .o_pending    (pending),
        .o_checked    (checked)
    );

    initial begin
        i_clk = 0;
        forever #5 i_clk = ~i_clk;
    end

    initial begin
        repeat (CYCLE_LIMIT) @(posedge i_clk);
        $display("timeout after %0d cycles", CYCLE_LIMIT);
        $display("end of test: mismatches");
        $finish;
    end

    // Result side: a random hold before each transfer, or one long hold on request.
    initial begin
        int n;
        forever begin
            if (hold_req) begin
                n = HOLD_CYCLES;
                hold_req = 0;
            end else begin
                n = rx_burst ? 0 : $urandom_range(0, 19);
            end
            if (n > 0) begin
                @(negedge i_clk);
                i_stall = 1;
                repeat (n) @(negedge i_clk);
                i_stall = 0;
            end
            do @(posedge i_clk); while (!(o_valid && !i_stall));
        end
    end

    function automatic t_brq_in rand_item(logic [2:0] f);
        t_brq_in d;
        d.func = f;
        d.rec_position = {$urandom(), $urandom()};
        case ($urandom_range(0, 3))
            0: d.rec_size = SIZE_W'($urandom_range(0, 3));
            1: d.rec_size = SIZE_W'($urandom_range(0, 9_000_000));
            2: d.rec_size = '1;
            default: d.rec_size = SIZE_W'($urandom());
        endcase
        d.rec_type = TYPE_W'($urandom_range(REC_PUT, REC_OTHER));
        d.rec_origin_bucket = ORIGIN_W'($urandom());
        return d;
    endfunction

    task automatic send_item(t_brq_in d);
        int gap;
        gap = tx_burst ? 0 : $urandom_range(0, 19);
        repeat (gap) begin
            @(negedge i_clk);
            i_valid = 0;
        end
        @(negedge i_clk);
        i_valid   = 1;
        i_in_data = d;
        do @(posedge i_clk); while (o_stall);
        n_items++;
    endtask

    task automatic issue(logic [2:0] f);
        send_item(rand_item(f));
    endtask

    task automatic push_record(logic [POS_W-1:0] pos, logic [SIZE_W-1:0] size,
                               logic [TYPE_W-1:0] typ, logic [ORIGIN_W-1:0] org);
        t_brq_in d;
        d.func = FN_PUSH;
        d.rec_position = pos;
        d.rec_size = size;
        d.rec_type = typ;
        d.rec_origin_bucket = org;
        send_item(d);
    endtask

    task automatic cfg_write(logic [CIDX_W-1:0] idx, logic [CFG_W-1:0] val);
        @(negedge i_clk);
        i_cfg_we    = 1;
        i_cfg_index = idx;
        i_cfg_wdata = val;
    endtask

    // Waits until every expected result has been seen and the block is quiet.
    task automatic settle();
        @(negedge i_clk);
        i_valid = 0;
        while (pending != 0) @(negedge i_clk);
        repeat (4) @(negedge i_clk);
    endtask

    task automatic apply_setting(logic [5:0] count_lim, logic [31:0] size_lim,
                                 logic [7:0] retry, logic [8:0] cap, logic [9:0] bucket);
        settle();
        cfg_write(CFG_COUNT_LIMIT, CFG_W'(count_lim));
        cfg_write(CFG_SIZE_LIMIT, size_lim);
        cfg_write(CFG_RETRY_WAIT, CFG_W'(retry));
        cfg_write(CFG_CAPACITY, CFG_W'(cap));
        cfg_write(CFG_BUCKET, CFG_W'(bucket));
        @(negedge i_clk);
        i_cfg_we = 0;
        n_settings++;
    endtask

    // Mostly whole push / fetch / ack rounds with random content, plus random noise.
    task automatic run_random(int n);
        int stop, k;
        stop = n_items + n;
        tx_burst = ($urandom_range(0, 3) == 0);
        rx_burst = ($urandom_range(0, 3) == 0);
        while (n_items < stop) begin
            if ($urandom_range(0, 9) < 7) begin
                k = ($urandom_range(0, 5) == 0) ? $urandom_range(6, 36) : $urandom_range(1, 5);
                repeat (k) issue(FN_PUSH);
                issue(FN_FETCH);
                if ($urandom_range(0, 2) == 0) issue(FN_FETCH);
                if ($urandom_range(0, 1) == 1) begin
                    issue(FN_ACK_FAIL);
                    repeat ($urandom_range(0, 4)) issue(FN_TICK);
                    issue(FN_FETCH);
                end
                issue(FN_ACK_OK);
            end else begin
                issue(3'($urandom_range(0, 7)));
            end
        end
        tx_burst = 0;
        rx_burst = 0;
    endtask

    initial begin
        logic [31:0] size_pick;
        i_rst_n     = 0;
        i_valid     = 0;
        i_in_data   = '0;
        i_stall     = 0;
        i_cfg_we    = 0;
        i_cfg_index = '0;
        i_cfg_wdata = '0;
        n_items     = 0;
        n_settings  = 1;
        tx_burst    = 0;
        rx_burst    = 0;
        hold_req    = 0;
        repeat (9) @(negedge i_clk);
        i_rst_n = 1;

        // Directed part under the reset settings.
        issue(FN_FETCH);
        issue(FN_ACK_OK);
        issue(FN_ACK_FAIL);
        issue(FN_TICK);
        for (int f = FN_TICK + 1; f < (1 << $bits(i_in_data.func)); f++) issue(3'(f));
        push_record('0, '0, REC_PUT, '0);
        push_record('1, '1, REC_DELETE, '1);
        push_record({16{4'h5}}, {6{4'hA}}, REC_OTHER, 10'h2AA);
        push_record({16{4'hA}}, {6{4'h5}}, REC_DELETE, 10'h155);
        issue(FN_FETCH);
        issue(FN_FETCH);
        issue(FN_PUSH);
        issue(FN_ACK_FAIL);
        issue(FN_TICK);
        issue(FN_FETCH);
        issue(FN_TICK);
        issue(FN_TICK);
        issue(FN_ACK_OK);
        issue(FN_FETCH);
        issue(FN_ACK_OK);
        issue(FN_FETCH);

        // Writes to unused register indexes must change nothing.
        settle();
        for (int k = CFG_BUCKET + 1; k < (1 << CIDX_W); k++) cfg_write(CIDX_W'(k), $urandom());
        @(negedge i_clk);
        i_cfg_we = 0;

        apply_setting(6'd1, 32'hFFFF_FFFF, 8'd0, 9'd256, 10'd1023);
        run_random(PHASE_ITEMS);
        apply_setting(6'd32, 32'hFFFF_FFFF, 8'd255, 9'd256, 10'd0);
        run_random(PHASE_ITEMS);
        apply_setting(6'd20, 32'd1, 8'd3, 9'd8, 10'($urandom()));
        run_random(PHASE_ITEMS);
        apply_setting(6'd63, 32'd20_000_000, 8'd1, 9'd0, 10'($urandom()));
        run_random(PHASE_ITEMS);
        apply_setting(6'd5, 32'd30_000_000, 8'd2, 9'd511, 10'd512);
        run_random(PHASE_ITEMS);
        apply_setting(6'd0, 32'd0, 8'd4, 9'd3, 10'($urandom()));
        run_random(PHASE_ITEMS);
        apply_setting(6'd12, 32'd25_000_000, 8'd0, 9'd1, 10'($urandom()));
        run_random(PHASE_ITEMS);
        size_pick = ($urandom_range(0, 1) == 1) ? $urandom() : $urandom_range(0, 40_000_000);
        apply_setting(6'($urandom()), size_pick, 8'($urandom()), 9'($urandom()),
                      10'($urandom()));
        run_random(PHASE_ITEMS);

        // Long result-side hold while pushes keep coming, so the input backs up.
        apply_setting(RST_COUNT_LIMIT, RST_SIZE_LIMIT, RST_RETRY_WAIT, RST_CAPACITY, 10'd0);
        tx_burst = 1;
        hold_req = 1;
        repeat (30) issue(FN_PUSH);
        issue(FN_FETCH);
        issue(FN_ACK_OK);
        tx_burst = 0;

        @(negedge i_clk);
        i_valid = 0;
        while (pending != 0) @(negedge i_clk);
        repeat (DRAIN_CYCLES) @(negedge i_clk);

        $display("Run covered %0d input transfers and %0d checked results under %0d settings.",
                 n_items, checked, n_settings);
        if (fail_count == 0 && pending == 0) begin
            $display("end of test: clean");
        end else begin
            $display("end of test: mismatches");
        end
        $finish;
    end

endmodule

/* files.f */
rtl/brq_pkg.sv
rtl/batching_retry_queue_top.sv
verif/brq_result_checker.sv
verif/batching_retry_queue_top_tb.sv
